FILE: rtl/core/frp_pkg.sv
// ----------------------------------------------------------------------------
// frp_pkg
// Shared types, constants and the CRC-8 update for the framed packet receiver.
// ----------------------------------------------------------------------------
package frp_pkg;

  localparam logic [7:0] HDR_BYTE0 = 8'h55;
  localparam logic [7:0] HDR_BYTE1 = 8'hAA;
  localparam logic [7:0] CRC_POLY  = 8'h8C;
  localparam logic [7:0] CRC_INIT  = 8'h00;

  // Only payload bytes 0 to 8 ever reach a result.
  localparam int USED_BYTES = 9;

  typedef logic [1:0] status_t;
  localparam status_t STS_GOOD    = 2'd0;
  localparam status_t STS_CRC_ERR = 2'd1;
  localparam status_t STS_LEN_ERR = 2'd2;

  typedef struct packed {
    status_t            status;
    logic signed [15:0] throttle;
    logic signed [15:0] brake;
    logic signed [15:0] front_angle;
    logic signed [15:0] rear_angle;
    logic        [7:0]  control_flags;
  } result_t;

  // Reflected CRC-8, one byte: eight shift steps on an 8-bit value.
  function automatic logic [7:0] crc8_update(input logic [7:0] crc, input logic [7:0] b);
    logic [7:0] c;
    c = crc ^ b;
    for (int i = 0; i < 8; i++) begin
      if (c[0]) begin
        c = (c >> 1) ^ CRC_POLY;
      end else begin
        c = c >> 1;
      end
    end
    return c;
  endfunction

  localparam logic [7:0] CRC_AFTER_HDR = crc8_update(crc8_update(CRC_INIT, HDR_BYTE0), HDR_BYTE1);

endpackage

FILE: rtl/core/frp_parser.sv
// ----------------------------------------------------------------------------
// frp_parser
// Frame state machine, CRC accumulator and payload capture; flags a result
// combinationally on the byte that finishes or fails a frame.
// ----------------------------------------------------------------------------
module frp_parser #(
  parameter int FRAME_BUFFER_BYTES = 16
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             byte_take,
  input  logic [7:0]       rx_byte,
  output logic             res_valid,
  output frp_pkg::result_t res
);
  import frp_pkg::*;

  localparam logic [7:0] LEN_MAX = 8'(FRAME_BUFFER_BYTES - 4);

  typedef enum logic [2:0] {
    PH_HUNT    = 3'd0,
    PH_LEN     = 3'd1,
    PH_PAYLOAD = 3'd2,
    PH_CRC     = 3'd3,
    PH_TRAILER = 3'd4
  } phase_t;

  phase_t     phase_r, phase_nxt;
  logic [7:0] prev_r, prev_nxt;
  logic [7:0] len_r, len_nxt;
  logic [7:0] cnt_r, cnt_nxt;
  logic [7:0] crc_r, crc_nxt;
  logic       trl_r, trl_nxt;
  logic [7:0] store_r [USED_BYTES];
  logic [7:0] crc_upd;
  logic [7:0] cnt_inc;

  assign crc_upd = crc8_update(crc_r, rx_byte);
  assign cnt_inc = cnt_r + 8'd1;

  always_comb begin
    phase_nxt = phase_r;
    prev_nxt  = prev_r;
    len_nxt   = len_r;
    cnt_nxt   = cnt_r;
    crc_nxt   = crc_r;
    trl_nxt   = trl_r;
    res_valid = 1'b0;
    res       = '0;
    case (phase_r)
      PH_LEN: begin
        crc_nxt = crc_upd;
        if (rx_byte > LEN_MAX) begin
          res_valid  = 1'b1;
          res.status = STS_LEN_ERR;
          phase_nxt  = PH_HUNT;
          prev_nxt   = '0;
          len_nxt    = '0;
          cnt_nxt    = '0;
          crc_nxt    = '0;
          trl_nxt    = 1'b0;
        end else begin
          len_nxt   = rx_byte;
          cnt_nxt   = '0;
          phase_nxt = (rx_byte == 8'd0) ? PH_CRC : PH_PAYLOAD;
        end
      end
      PH_PAYLOAD: begin
        crc_nxt = crc_upd;
        cnt_nxt = cnt_inc;
        if (cnt_inc >= len_r) begin
          phase_nxt = PH_CRC;
        end
      end
      PH_CRC: begin
        if (rx_byte != crc_r) begin
          res_valid  = 1'b1;
          res.status = STS_CRC_ERR;
          phase_nxt  = PH_HUNT;
          prev_nxt   = '0;
          len_nxt    = '0;
          cnt_nxt    = '0;
          crc_nxt    = '0;
        end else begin
          phase_nxt = PH_TRAILER;
        end
        trl_nxt = 1'b0;
      end
      PH_TRAILER: begin
        if (!trl_r) begin
          trl_nxt = 1'b1;
        end else begin
          res_valid         = 1'b1;
          res.status        = STS_GOOD;
          res.throttle      = {store_r[1], store_r[0]};
          res.brake         = {store_r[3], store_r[2]};
          res.front_angle   = {store_r[5], store_r[4]};
          res.rear_angle    = {store_r[7], store_r[6]};
          res.control_flags = store_r[8];
          phase_nxt         = PH_HUNT;
          prev_nxt          = '0;
          len_nxt           = '0;
          cnt_nxt           = '0;
          crc_nxt           = '0;
          trl_nxt           = 1'b0;
        end
      end
      default: begin
        // Hunting, and any code without meaning.
        if (rx_byte == HDR_BYTE1 && prev_r == HDR_BYTE0) begin
          crc_nxt   = CRC_AFTER_HDR;
          len_nxt   = '0;
          cnt_nxt   = '0;
          trl_nxt   = 1'b0;
          phase_nxt = PH_LEN;
        end else begin
          phase_nxt = PH_HUNT;
          prev_nxt  = rx_byte;
        end
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_HUNT;
      prev_r  <= '0;
      len_r   <= '0;
      cnt_r   <= '0;
      crc_r   <= '0;
      trl_r   <= 1'b0;
    end else if (byte_take) begin
      phase_r <= phase_nxt;
      prev_r  <= prev_nxt;
      len_r   <= len_nxt;
      cnt_r   <= cnt_nxt;
      crc_r   <= crc_nxt;
      trl_r   <= trl_nxt;
    end
  end

  // Capture payload bytes that can reach a result; later ones only feed the CRC.
  for (genvar i = 0; i < USED_BYTES; i++) begin : g_store
    always_ff @(posedge clk) begin
      if (byte_take && phase_r == PH_PAYLOAD && cnt_r == 8'(i)) begin
        store_r[i] <= rx_byte;
      end
    end
  end

endmodule

FILE: rtl/core/frp_out_buf.sv
// ----------------------------------------------------------------------------
// frp_out_buf
// Two-entry result buffer that decouples the parser from a stalling receiver.
// ----------------------------------------------------------------------------
module frp_out_buf (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push,
  input  frp_pkg::result_t push_data,
  input  logic             pop,
  output logic             full,
  output logic             not_empty,
  output frp_pkg::result_t head
);
  import frp_pkg::*;

  result_t    slot_r [2];
  logic       wr_ptr_r, rd_ptr_r;
  logic [1:0] cnt_r, cnt_nxt;

  assign full      = (cnt_r == 2'd2);
  assign not_empty = (cnt_r != 2'd0);
  assign head      = slot_r[rd_ptr_r];

  always_comb begin
    cnt_nxt = cnt_r;
    if (push && !pop) begin
      cnt_nxt = cnt_r + 2'd1;
    end else if (pop && !push) begin
      cnt_nxt = cnt_r - 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      cnt_r    <= '0;
    end else begin
      cnt_r <= cnt_nxt;
      if (push) begin
        wr_ptr_r <= ~wr_ptr_r;
      end
      if (pop) begin
        rd_ptr_r <= ~rd_ptr_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slot_r[wr_ptr_r] <= push_data;
    end
  end

endmodule

FILE: rtl/core/framed_command_packet_receiver_top.sv
// ----------------------------------------------------------------------------
// framed_command_packet_receiver_top
// Serial frame parser: header 0x55 0xAA, length, payload, CRC-8, trailer.
// ----------------------------------------------------------------------------
// Usage:
//   Feed received bytes on the in_ channel (in_valid / in_stall, payload
//   in_rx_byte). A byte transfers on a clock edge with in_valid high and
//   in_stall low. One byte is taken per cycle, back to back, unless stalled.
//   Results leave on the out_ channel (out_valid / out_stall). A result is
//   produced by the second trailer byte of a good frame (status 0, with the
//   four signed values and the flags), by a bad CRC byte (status 1) or by a
//   length above FRAME_BUFFER_BYTES - 4 (status 2); error results carry zero
//   fields. A result shows the cycle after the byte causing it transfers
//   if no older result waits. Throughput: one byte per cycle when not stalled,
//   set by the combinational parser state update and bytewise CRC step.
//   A two-entry result buffer sits between parser and output, so input keeps
//   flowing while one result waits. in_stall is high while both entries are
//   full, which only a receiver holding out_stall can cause; it stays high
//   through the cycle in which the older result transfers and drops after.
//   Stalled results hold steady.
//   Reset (rst_n low, synchronous) returns the parser to header hunting and
//   empties the result buffer; captured payload bytes are not cleared.
// ----------------------------------------------------------------------------
module framed_command_packet_receiver_top #(
  parameter int FRAME_BUFFER_BYTES = 16
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic        [7:0]  in_rx_byte,
  output logic               out_valid,
  input  logic               out_stall,
  output frp_pkg::status_t   out_status,
  output logic signed [15:0] out_throttle,
  output logic signed [15:0] out_brake,
  output logic signed [15:0] out_front_angle,
  output logic signed [15:0] out_rear_angle,
  output logic        [7:0]  out_control_flags
);
  import frp_pkg::*;

  logic    byte_take;
  logic    res_valid;
  result_t res;
  logic    buf_full;
  logic    buf_pop;
  result_t head;

  // Transfer a byte whenever the buffer has room for a possible result.
  assign in_stall  = buf_full;
  assign byte_take = in_valid && !buf_full;
  assign buf_pop   = out_valid && !out_stall;

  frp_parser #(
    .FRAME_BUFFER_BYTES(FRAME_BUFFER_BYTES)
  ) u_parser (
    .clk      (clk),
    .rst_n    (rst_n),
    .byte_take(byte_take),
    .rx_byte  (in_rx_byte),
    .res_valid(res_valid),
    .res      (res)
  );

  frp_out_buf u_out_buf (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (byte_take && res_valid),
    .push_data(res),
    .pop      (buf_pop),
    .full     (buf_full),
    .not_empty(out_valid),
    .head     (head)
  );

  // Drive the result fields from the oldest buffered entry.
  assign out_status        = head.status;
  assign out_throttle      = head.throttle;
  assign out_brake         = head.brake;
  assign out_front_angle   = head.front_angle;
  assign out_rear_angle    = head.rear_angle;
  assign out_control_flags = head.control_flags;

endmodule
